[rtl/jtr_pkg.sv]
// Package for the joint trajectory resampler.
// Holds the field widths, register map and arithmetic constants.
// No dependencies; used by joint_trajectory_resampler_core.
package jtr_pkg;

    localparam int TIME_W      = 32;
    localparam int NST_W       = 33;
    localparam int JOINT_W     = 32;
    localparam int NUM_FIELDS  = 6;
    localparam int S_DATA_W    = TIME_W + NUM_FIELDS * JOINT_W;
    localparam int M_DATA_W    = NUM_FIELDS * JOINT_W;

    localparam int PERIOD_W    = 20;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(20000);

    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam logic REG_SAMPLE_PERIOD = 1'b0;

    localparam int FRAC_W      = 16;
    localparam int ALPHA_W     = FRAC_W + 1;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1) << FRAC_W;

    localparam int STEP_W      = 6;
    localparam logic [STEP_W-1:0] ALPHA_STEPS = STEP_W'(FRAC_W);
    localparam logic [STEP_W-1:0] SKIP_STEPS  = STEP_W'(TIME_W);

endpackage

[rtl/joint_trajectory_resampler_core.sv]
// Joint trajectory resampler, top level.
// Turns timed waypoints into fixed-period joint samples by linear blending.
// Depends on jtr_pkg.

// The block takes one waypoint beat at a time and answers with up to
// MAX_SAMPLES_PER_POINT sample beats, the last of them marked by tlast and,
// when due samples were dropped, by tuser. All work runs through one shared
// shift-subtract divider and one 33 x 18 multiplier under a small sequencer,
// and s_tready is high only between waypoints. A waypoint is taken in the
// idle state; then, per sample, a check step runs, a division when the sample
// lies strictly inside the segment, a multiply and an accumulate step per
// joint, and a hand-over of the beat to the output register; when samples
// are dropped, a further division finds the next sample time. The sample
// period register sits at byte address 0 of the APB port.
module joint_trajectory_resampler_core #(
    parameter int ACTIVE_JOINTS         = 6,
    parameter int MAX_SAMPLES_PER_POINT = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [jtr_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [jtr_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [jtr_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,

    input  logic                             s_tvalid,
    output logic                             s_tready,
    // point_time_us, joint_1 .. joint_6
    input  logic [jtr_pkg::S_DATA_W-1:0]     s_tdata,
    // start_req
    input  logic                             s_tuser,

    output logic                             m_tvalid,
    input  logic                             m_tready,
    // out_joint_1 .. out_joint_6
    output logic [jtr_pkg::M_DATA_W-1:0]     m_tdata,
    // last_in_run
    output logic                             m_tlast,
    // overflow
    output logic                             m_tuser
);

    import jtr_pkg::*;

    localparam int CNT_W  = $clog2(MAX_SAMPLES_PER_POINT + 1);
    localparam int JIDX_W = (ACTIVE_JOINTS > 1) ? $clog2(ACTIVE_JOINTS) : 1;
    localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(MAX_SAMPLES_PER_POINT);
    localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(MAX_SAMPLES_PER_POINT - 1);
    localparam logic [JIDX_W-1:0] JIDX_LAST = JIDX_W'(ACTIVE_JOINTS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV_ALPHA,
        ST_MUL,
        ST_ACC,
        ST_EMIT,
        ST_DIV_SKIP
    } state_t;

    state_t                  state_reg, state_next;
    logic [PERIOD_W-1:0]     period_reg, period_next;
    logic                    have_prev_reg, have_prev_next;
    logic [TIME_W-1:0]       prev_time_reg, prev_time_next;
    logic [NST_W-1:0]        nst_reg, nst_next;
    logic [TIME_W-1:0]       t2_reg, t2_next;
    logic [TIME_W-1:0]       seg_len_reg, seg_len_next;
    logic [JOINT_W-1:0]      prev_pos_reg [ACTIVE_JOINTS];
    logic [JOINT_W-1:0]      prev_pos_next [ACTIVE_JOINTS];
    logic [JOINT_W-1:0]      cur_pos_reg [ACTIVE_JOINTS];
    logic [JOINT_W-1:0]      cur_pos_next [ACTIVE_JOINTS];
    logic [JOINT_W-1:0]      res_reg [ACTIVE_JOINTS];
    logic [JOINT_W-1:0]      res_next [ACTIVE_JOINTS];
    logic [ALPHA_W-1:0]      alpha_reg, alpha_next;
    logic [TIME_W-1:0]       rem_reg, rem_next;
    logic [TIME_W-1:0]       num_reg, num_next;
    logic [TIME_W-1:0]       den_reg, den_next;
    logic [FRAC_W-1:0]       quo_reg, quo_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic [JIDX_W-1:0]       jidx_reg, jidx_next;
    logic [JOINT_W-1:0]      mul_reg, mul_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    last_reg, last_next;
    logic                    ovf_reg, ovf_next;
    logic [M_DATA_W-1:0]     out_data_reg, out_data_next;
    logic                    out_last_reg, out_last_next;
    logic                    out_ovf_reg, out_ovf_next;
    logic                    out_valid_reg, out_valid_next;

    logic [PERIOD_W-1:0]     period_eff;
    logic [TIME_W-1:0]       in_time;
    logic [JOINT_W-1:0]      in_pos [ACTIVE_JOINTS];
    logic                    start_eff;
    logic [TIME_W-1:0]       seg_t1;
    logic                    due;
    logic [NST_W:0]          nst_plus;
    logic [TIME_W-1:0]       offset;
    logic [TIME_W:0]         div_trial;
    logic                    div_ge;
    logic [TIME_W-1:0]       div_rem;
    logic [FRAC_W-1:0]       div_quo;
    logic signed [JOINT_W:0] diff;
    logic signed [JOINT_W+ALPHA_W:0] prod;
    logic [NST_W:0]          skip_time;
    logic [M_DATA_W-1:0]     res_packed;
    logic                    cfg_write;

    genvar g;
    generate
        for (g = 0; g < NUM_FIELDS; g++)
        begin : g_pack
            if (g < ACTIVE_JOINTS)
            begin : g_used
                assign res_packed[g*JOINT_W +: JOINT_W] = res_reg[g];
            end
            else
            begin : g_unused
                assign res_packed[g*JOINT_W +: JOINT_W] = '0;
            end
        end
    endgenerate

    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_SAMPLE_PERIOD)
                       ? {{(APB_DATA_W-PERIOD_W){1'b0}}, period_reg} : '0;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_SAMPLE_PERIOD);

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tlast   = out_last_reg;
    assign m_tuser   = out_ovf_reg;

    assign period_eff = (period_reg == '0) ? PERIOD_W'(1) : period_reg;
    assign in_time    = s_tdata[TIME_W-1:0];
    assign start_eff  = s_tuser || !have_prev_reg;
    assign seg_t1     = start_eff ? in_time : prev_time_reg;
    assign due        = (nst_reg <= {1'b0, t2_reg});
    assign nst_plus   = {1'b0, nst_reg} + (NST_W+1)'(period_eff);
    assign offset     = nst_reg[TIME_W-1:0] - prev_time_reg;

    // One restoring divide step: remainder shifts in the next dividend bit.
    assign div_trial  = {rem_reg, num_reg[TIME_W-1]};
    assign div_ge     = (div_trial >= {1'b0, den_reg});
    assign div_rem    = div_ge ? TIME_W'(div_trial - {1'b0, den_reg})
                               : div_trial[TIME_W-1:0];
    assign div_quo    = {quo_reg[FRAC_W-2:0], div_ge};

    assign diff = $signed({cur_pos_reg[jidx_reg][JOINT_W-1], cur_pos_reg[jidx_reg]})
                - $signed({prev_pos_reg[jidx_reg][JOINT_W-1], prev_pos_reg[jidx_reg]});
    assign prod = diff * $signed({1'b0, alpha_reg});

    assign skip_time = {1'b0, t2_reg} - (NST_W+1)'(div_rem) + (NST_W+1)'(period_eff);

    always_comb
    begin
        state_next     = state_reg;
        period_next    = period_reg;
        have_prev_next = have_prev_reg;
        prev_time_next = prev_time_reg;
        nst_next       = nst_reg;
        t2_next        = t2_reg;
        seg_len_next   = seg_len_reg;
        prev_pos_next  = prev_pos_reg;
        cur_pos_next   = cur_pos_reg;
        res_next       = res_reg;
        alpha_next     = alpha_reg;
        rem_next       = rem_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        quo_next       = quo_reg;
        step_next      = step_reg;
        jidx_next      = jidx_reg;
        mul_next       = mul_reg;
        cnt_next       = cnt_reg;
        last_next      = last_reg;
        ovf_next       = ovf_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;
        out_valid_next = out_valid_reg;

        for (int k = 0; k < ACTIVE_JOINTS; k++)
        begin
            in_pos[k] = s_tdata[TIME_W + k*JOINT_W +: JOINT_W];
        end

        if (cfg_write)
        begin
            period_next = pwdata[PERIOD_W-1:0];
        end

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (start_eff)
                    begin
                        prev_pos_next = in_pos;
                        nst_next      = '0;
                    end
                    prev_time_next = seg_t1;
                    have_prev_next = 1'b1;
                    t2_next        = in_time;
                    cur_pos_next   = in_pos;
                    seg_len_next   = (in_time > seg_t1) ? (in_time - seg_t1) : '0;
                    cnt_next       = '0;
                    state_next     = ST_CHECK;
                end
            end

            ST_CHECK:
            begin
                if (due && (cnt_reg < CNT_MAX))
                begin
                    last_next = (nst_plus > {2'b00, t2_reg}) || (cnt_reg == CNT_LAST);
                    ovf_next  = (nst_plus <= {2'b00, t2_reg}) && (cnt_reg == CNT_LAST);
                    jidx_next = '0;
                    if ((seg_len_reg != '0) && (nst_reg > {1'b0, prev_time_reg}))
                    begin
                        if (offset >= seg_len_reg)
                        begin
                            alpha_next = ALPHA_ONE;
                            state_next = ST_MUL;
                        end
                        else
                        begin
                            rem_next   = offset;
                            num_next   = '0;
                            den_next   = seg_len_reg;
                            quo_next   = '0;
                            step_next  = ALPHA_STEPS;
                            state_next = ST_DIV_ALPHA;
                        end
                    end
                    else
                    begin
                        alpha_next = '0;
                        state_next = ST_MUL;
                    end
                end
                else if (due)
                begin
                    rem_next   = '0;
                    num_next   = t2_reg - nst_reg[TIME_W-1:0];
                    den_next   = TIME_W'(period_eff);
                    quo_next   = '0;
                    step_next  = SKIP_STEPS;
                    state_next = ST_DIV_SKIP;
                end
                else
                begin
                    prev_time_next = t2_reg;
                    prev_pos_next  = cur_pos_reg;
                    state_next     = ST_IDLE;
                end
            end

            ST_DIV_ALPHA:
            begin
                rem_next  = div_rem;
                num_next  = {num_reg[TIME_W-2:0], 1'b0};
                quo_next  = div_quo;
                step_next = step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1))
                begin
                    alpha_next = {1'b0, div_quo};
                    state_next = ST_MUL;
                end
            end

            ST_DIV_SKIP:
            begin
                rem_next  = div_rem;
                num_next  = {num_reg[TIME_W-2:0], 1'b0};
                quo_next  = div_quo;
                step_next = step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1))
                begin
                    nst_next       = skip_time[NST_W-1:0];
                    prev_time_next = t2_reg;
                    prev_pos_next  = cur_pos_reg;
                    state_next     = ST_IDLE;
                end
            end

            ST_MUL:
            begin
                // Bits above the fraction are the floored blend, kept modulo 2^32.
                mul_next   = prod[FRAC_W +: JOINT_W];
                state_next = ST_ACC;
            end

            ST_ACC:
            begin
                res_next[jidx_reg] = prev_pos_reg[jidx_reg] + mul_reg;
                if (jidx_reg == JIDX_LAST)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    jidx_next  = jidx_reg + JIDX_W'(1);
                    state_next = ST_MUL;
                end
            end

            ST_EMIT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_data_next  = res_packed;
                    out_last_next  = last_reg;
                    out_ovf_next   = ovf_reg;
                    out_valid_next = 1'b1;
                    nst_next       = nst_plus[NST_W-1:0];
                    cnt_next       = cnt_reg + CNT_W'(1);
                    state_next     = ST_CHECK;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            period_reg    <= PERIOD_RESET;
            have_prev_reg <= 1'b0;
            prev_time_reg <= '0;
            nst_reg       <= '0;
            t2_reg        <= '0;
            seg_len_reg   <= '0;
            for (int k = 0; k < ACTIVE_JOINTS; k++)
            begin
                prev_pos_reg[k] <= '0;
                cur_pos_reg[k]  <= '0;
                res_reg[k]      <= '0;
            end
            alpha_reg     <= '0;
            rem_reg       <= '0;
            num_reg       <= '0;
            den_reg       <= '0;
            quo_reg       <= '0;
            step_reg      <= '0;
            jidx_reg      <= '0;
            mul_reg       <= '0;
            cnt_reg       <= '0;
            last_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            out_data_reg  <= '0;
            out_last_reg  <= 1'b0;
            out_ovf_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            period_reg    <= period_next;
            have_prev_reg <= have_prev_next;
            prev_time_reg <= prev_time_next;
            nst_reg       <= nst_next;
            t2_reg        <= t2_next;
            seg_len_reg   <= seg_len_next;
            prev_pos_reg  <= prev_pos_next;
            cur_pos_reg   <= cur_pos_next;
            res_reg       <= res_next;
            alpha_reg     <= alpha_next;
            rem_reg       <= rem_next;
            num_reg       <= num_next;
            den_reg       <= den_next;
            quo_reg       <= quo_next;
            step_reg      <= step_next;
            jidx_reg      <= jidx_next;
            mul_reg       <= mul_next;
            cnt_reg       <= cnt_next;
            last_reg      <= last_next;
            ovf_reg       <= ovf_next;
            out_data_reg  <= out_data_next;
            out_last_reg  <= out_last_next;
            out_ovf_reg   <= out_ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[tb/joint_trajectory_resampler_core_tb.sv]
// Self-checking testbench for joint_trajectory_resampler_core.
// Drives timed waypoints and APB period writes, predicts every sample beat
// in place and compares them in order. Depends on jtr_pkg and the core RTL.
module joint_trajectory_resampler_core_tb;
    import jtr_pkg::*;

    localparam int MAX_SAMPLES = 64;
    localparam int IDLE_CYCLES = 100;
    localparam int LIMIT_CYCLES = 4_000_000;
    localparam int ITEMS_PER_PHASE = 64;
    localparam logic [APB_ADDR_W-1:0] PERIOD_ADDR = APB_ADDR_W'(4 * int'(REG_SAMPLE_PERIOD));
    localparam logic [APB_ADDR_W-1:0] UNMAPPED_ADDR =
        APB_ADDR_W'(4 * (int'(REG_SAMPLE_PERIOD) + 1));

    typedef logic [NUM_FIELDS-1:0][JOINT_W-1:0] joint_vec_t;

    typedef struct packed {
        logic                start;
        joint_vec_t          joints;
        logic [TIME_W-1:0]   t;
    } waypoint_t;

    typedef struct packed {
        joint_vec_t joints;
        logic       last;
        logic       ovf;
    } sample_t;

    typedef enum int {RX_ALWAYS, RX_COIN, RX_PATTERN, RX_MOSTLY} rx_mode_t;

    // j6 .. j1
    localparam joint_vec_t POSE_A = {32'h5555_5555, 32'h0000_0001, 32'hFFFF_FFFF,
                                     32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
    localparam joint_vec_t POSE_B = {32'hAAAA_AAAA, 32'hFFFF_FFFF, 32'h0000_0001,
                                     32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF};

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // point_time_us, joint_1 .. joint_6
    logic [S_DATA_W-1:0]   s_tdata = '0;
    // start_req
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // out_joint_1 .. out_joint_6
    logic [M_DATA_W-1:0]   m_tdata;
    // last_in_run
    logic                  m_tlast;
    // overflow
    logic                  m_tuser;

    waypoint_t waypoint_queue[$];
    sample_t   pending_samples[$];
    int        mismatches = 0;

    logic [PERIOD_W-1:0] period_us = PERIOD_RESET;
    longint              last_wp_time = 0;
    joint_vec_t          last_wp_pos = '0;
    longint              next_due_us = 0;
    bit                  have_waypoint = 1'b0;

    logic      took_beat = 1'b0;
    int        burst_left = 1;
    int        gap_left = 0;
    int        bursts = 0;
    logic      drain_hold = 1'b0;
    waypoint_t next_wp;
    rx_mode_t  rx_mode = RX_ALWAYS;
    int        rx_left = 0;
    sample_t   want;
    joint_vec_t got_joints;

    joint_trajectory_resampler_core #(
        .ACTIVE_JOINTS         (NUM_FIELDS),
        .MAX_SAMPLES_PER_POINT (MAX_SAMPLES)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic void resample_waypoint(input logic start, input logic [TIME_W-1:0] t_in,
                                              input joint_vec_t pos);
        longint  step;
        longint  t_now;
        longint  seg;
        longint  alpha;
        longint  p1;
        longint  p2;
        longint  v;
        longint  k;
        int      n;
        sample_t s;
        step = (period_us == '0) ? 1 : longint'(period_us);
        t_now = longint'(t_in);
        if (start || !have_waypoint)
        begin
            last_wp_time = t_now;
            last_wp_pos = pos;
            next_due_us = 0;
            have_waypoint = 1'b1;
        end
        seg = (t_now > last_wp_time) ? t_now - last_wp_time : 0;
        n = 0;
        while (next_due_us <= t_now && n < MAX_SAMPLES)
        begin
            alpha = 0;
            if (seg != 0 && next_due_us > last_wp_time)
            begin
                alpha = ((next_due_us - last_wp_time) <<< 16) / seg;
                if (alpha > 65536)
                    alpha = 65536;
            end
            for (int j = 0; j < NUM_FIELDS; j++)
            begin
                p1 = $signed(last_wp_pos[j]);
                p2 = $signed(pos[j]);
                v = p1 + (((p2 - p1) * alpha) >>> 16);
                s.joints[j] = v[JOINT_W-1:0];
            end
            n++;
            next_due_us += step;
            s.last = !(next_due_us <= t_now && n < MAX_SAMPLES);
            s.ovf = s.last && (next_due_us <= t_now);
            pending_samples.push_back(s);
        end
        if (next_due_us <= t_now)
        begin
            k = (t_now - next_due_us) / step;
            next_due_us += step * (k + 1);
        end
        last_wp_time = t_now;
        last_wp_pos = pos;
    endfunction

    function automatic logic [JOINT_W-1:0] pick_joint(input logic [JOINT_W-1:0] prev);
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2, 3: return $urandom();
            default: return prev + $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
        endcase
    endfunction

    function automatic void push_waypoint(input logic start, input logic [TIME_W-1:0] t,
                                          input joint_vec_t joints);
        waypoint_t wp;
        wp.start = start;
        wp.t = t;
        wp.joints = joints;
        waypoint_queue.push_back(wp);
    endfunction

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (addr == PERIOD_ADDR)
            period_us = data[PERIOD_W-1:0];
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic check_period_readback();
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= PERIOD_ADDR;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== APB_DATA_W'(period_us))
        begin
            $display("%0t: sample_period_us read expected %h got %h", $time,
                     APB_DATA_W'(period_us), prdata);
            mismatches++;
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_period(input logic [APB_DATA_W-1:0] value);
        apb_write(PERIOD_ADDR, value);
        check_period_readback();
    endtask

    task automatic wait_until_idle();
        while (waypoint_queue.size() != 0 || s_tvalid || pending_samples.size() != 0)
            @(posedge clk);
        repeat (IDLE_CYCLES) @(posedge clk);
    endtask

    task automatic add_random_waypoints(input int count);
        int         r;
        longint     step;
        longint     t;
        longint     gen_t;
        joint_vec_t gen_pos;
        joint_vec_t js;
        logic       st;
        step = (period_us == '0) ? 1 : longint'(period_us);
        gen_t = 0;
        gen_pos = '0;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            for (int j = 0; j < NUM_FIELDS; j++)
                js[j] = pick_joint(gen_pos[j]);
            if (i == 0 || r < 8)
            begin
                st = 1'b1;
                t = (r < 2) ? longint'($urandom()) : longint'($urandom_range(0, 32'(3 * step)));
            end
            else if (r < 20)
            begin
                st = ($urandom_range(0, 3) == 0);
                t = longint'($urandom());
                for (int j = 0; j < NUM_FIELDS; j++)
                    js[j] = $urandom();
            end
            else
            begin
                st = 1'b0;
                if (r < 24)
                    t = gen_t + step * longint'($urandom_range(64, 200));
                else if (r < 30)
                    t = gen_t;
                else
                    t = gen_t + longint'($urandom_range(0, 32'(3 * step)));
                if (t > 64'hFFFF_FFFF)
                begin
                    st = 1'b1;
                    t = longint'($urandom_range(0, 32'(step)));
                end
            end
            gen_t = t;
            gen_pos = js;
            push_waypoint(st, t[TIME_W-1:0], js);
        end
    endtask

    // Waypoint source: bursts of beats with random gaps, and now and then a
    // pause until every sample owed so far has come back.
    always @(negedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || took_beat)
        begin
            if (drain_hold)
            begin
                s_tvalid <= 1'b0;
                if (pending_samples.size() == 0)
                    drain_hold <= 1'b0;
            end
            else if (gap_left != 0)
            begin
                s_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (waypoint_queue.size() != 0)
            begin
                next_wp = waypoint_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= next_wp.start;
                s_tdata <= {next_wp.joints, next_wp.t};
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 8);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    bursts <= bursts + 1;
                    drain_hold <= (bursts % 12 == 11);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(16, 128);
            m_tready <= 1'b1;
        end
        else
        begin
            rx_left <= rx_left - 1;
            case (rx_mode)
                RX_ALWAYS: m_tready <= 1'b1;
                RX_COIN: m_tready <= 1'($urandom_range(0, 1));
                RX_PATTERN: m_tready <= (rx_left % 5 == 0);
                default: m_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        took_beat <= rst_n && s_tvalid && s_tready;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_samples.size() == 0)
                begin
                    $display("%0t: unexpected sample beat %h last %b ovf %b", $time,
                             m_tdata, m_tlast, m_tuser);
                    mismatches++;
                end
                else
                begin
                    want = pending_samples.pop_front();
                    got_joints = m_tdata;
                    for (int j = 0; j < NUM_FIELDS; j++)
                        if (got_joints[j] !== want.joints[j])
                        begin
                            $display("%0t: out_joint_%0d expected %h got %h", $time, j + 1,
                                     want.joints[j], got_joints[j]);
                            mismatches++;
                        end
                    if (m_tlast !== want.last)
                    begin
                        $display("%0t: last_in_run expected %b got %b", $time, want.last,
                                 m_tlast);
                        mismatches++;
                    end
                    if (m_tuser !== want.ovf)
                    begin
                        $display("%0t: overflow expected %b got %b", $time, want.ovf, m_tuser);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                resample_waypoint(s_tuser, s_tdata[TIME_W-1:0], s_tdata[S_DATA_W-1:TIME_W]);
        end
    end

    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        check_period_readback();

        // A plain waypoint with nothing before it acts as a trajectory start.
        push_waypoint(1'b0, 32'd0, POSE_A);
        push_waypoint(1'b0, 32'd50000, POSE_B);
        push_waypoint(1'b0, 32'd60000, POSE_A);
        push_waypoint(1'b0, 32'd60000, POSE_B);
        push_waypoint(1'b0, 32'd30000, POSE_A);
        push_waypoint(1'b1, 32'd100000, POSE_B);
        push_waypoint(1'b0, 32'd2100000, POSE_A);
        push_waypoint(1'b0, 32'd2130000, POSE_B);
        wait_until_idle();

        // A period of zero runs as one microsecond.
        set_period(32'd0);
        push_waypoint(1'b1, 32'd5, POSE_A);
        push_waypoint(1'b0, 32'd200, POSE_B);
        push_waypoint(1'b0, 32'd201, POSE_A);
        wait_until_idle();

        apb_write(UNMAPPED_ADDR, 32'd7);
        set_period(32'hFFFF_FFFF);
        push_waypoint(1'b1, 32'hFFFF_FFFF, POSE_B);
        push_waypoint(1'b0, 32'hFFFF_FFFF, POSE_A);
        push_waypoint(1'b1, 32'd0, POSE_A);
        wait_until_idle();

        set_period(32'd20000);
        add_random_waypoints(ITEMS_PER_PHASE);
        wait_until_idle();
        set_period(32'd1);
        add_random_waypoints(ITEMS_PER_PHASE);
        wait_until_idle();
        set_period(32'd1000000);
        add_random_waypoints(ITEMS_PER_PHASE);
        wait_until_idle();
        set_period($urandom_range(2, 999999));
        add_random_waypoints(ITEMS_PER_PHASE);
        wait_until_idle();
        set_period(32'h000F_FFFF);
        add_random_waypoints(ITEMS_PER_PHASE);
        wait_until_idle();
        set_period(32'd0);
        add_random_waypoints(ITEMS_PER_PHASE);
        wait_until_idle();
        set_period($urandom_range(2, 999999));
        add_random_waypoints(ITEMS_PER_PHASE);
        wait_until_idle();

        if (mismatches == 0 && pending_samples.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
